// ===== design/rc4_pkg.sv =====
`default_nettype none
package rc4_pkg;

	localparam int MAX_KEY_BYTES = 16;
	localparam int KEY_W         = MAX_KEY_BYTES * 8;
	localparam int LEN_W         = $clog2(MAX_KEY_BYTES + 1);
	localparam int KIDX_W        = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 64;
	localparam int RAW_LEN_W     = 5;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 2'd2;

	localparam logic OP_INIT = 1'b0;
	localparam logic OP_DATA = 1'b1;

	typedef struct packed {
		logic       op;
		logic [7:0] data_in;
		logic       last_byte;
	} in_t;

	typedef struct packed {
		logic [7:0] data_out;
		logic       last_out;
	} out_t;

	typedef struct packed {
		logic [MAX_KEY_BYTES-1:0][7:0] bytes;
		logic [LEN_W-1:0]              len;
	} key_cfg_t;

endpackage
`default_nettype wire

// ===== design/rc4_core.sv =====
`default_nettype none
module rc4_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rc4_pkg::key_cfg_t key_cfg,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire rc4_pkg::in_t      in_data,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output rc4_pkg::out_t          out_data
);

	typedef enum logic [3:0] {
		IDLE, FILL, K_RD, K_SK, K_SJ, K_WJ, D_RI, D_SI, D_SJ, D_WJ, D_OUT
	} state_t;

	state_t                     state_q;
	logic [7:0]                 k_q;
	logic [rc4_pkg::KIDX_W-1:0] kidx_q;
	logic [7:0]                 jk_q;
	logic [7:0]                 i_q;
	logic [7:0]                 j_q;
	logic [7:0]                 si_q;
	logic [7:0]                 sj_q;
	logic                       fwd_q;
	logic [7:0]                 din_q;
	logic                       last_q;
	logic                       out_valid_q;
	rc4_pkg::out_t              out_q;

	logic [7:0] perm_mem [256];
	logic [7:0] rdata_q;

	logic       re, we;
	logic [7:0] raddr, waddr, wdata;
	logic [7:0] opa, opb, opc, sum;
	logic [7:0] ks;
	logic       kidx_wrap;

	// adder shared by the sums of j, i and the keystream index
	assign sum = opa + opb + opc;

	assign kidx_wrap = (rc4_pkg::LEN_W'(kidx_q) == key_cfg.len - rc4_pkg::LEN_W'(1));
	assign ks        = fwd_q ? si_q : rdata_q;

	always_comb begin
		opa   = 8'd0;
		opb   = 8'd0;
		opc   = 8'd0;
		re    = 1'b0;
		we    = 1'b0;
		raddr = sum;
		waddr = k_q;
		wdata = k_q;
		unique case (state_q)
			FILL: begin
				we = 1'b1;
			end
			K_RD: begin
				re    = 1'b1;
				raddr = k_q;
			end
			K_SK: begin
				opa = jk_q;
				opb = rdata_q;
				opc = key_cfg.bytes[kidx_q];
				re  = 1'b1;
			end
			K_SJ: begin
				we    = 1'b1;
				wdata = rdata_q;
			end
			K_WJ: begin
				we    = 1'b1;
				waddr = jk_q;
				wdata = si_q;
			end
			D_RI: begin
				opa = i_q;
				opb = 8'd1;
				re  = 1'b1;
			end
			D_SI: begin
				opa = j_q;
				opb = rdata_q;
				re  = 1'b1;
			end
			D_SJ: begin
				we    = 1'b1;
				waddr = i_q;
				wdata = rdata_q;
			end
			D_WJ: begin
				opa   = si_q;
				opb   = sj_q;
				re    = 1'b1;
				we    = 1'b1;
				waddr = j_q;
				wdata = si_q;
			end
			default: begin
			end
		endcase
	end

	// read returns the old word when the same address is written
	always_ff @(posedge clk) begin
		if (re)
			rdata_q <= perm_mem[raddr];
		if (we)
			perm_mem[waddr] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			i_q         <= 8'd0;
			j_q         <= 8'd0;
			k_q         <= 8'd0;
			kidx_q      <= '0;
			jk_q        <= 8'd0;
			si_q        <= 8'd0;
			sj_q        <= 8'd0;
			fwd_q       <= 1'b0;
			din_q       <= 8'd0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (state_q == D_OUT && (!out_valid_q || !out_stall))
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				IDLE: begin
					if (in_valid) begin
						din_q  <= in_data.data_in;
						last_q <= in_data.last_byte;
						if (in_data.op == rc4_pkg::OP_DATA)
							state_q <= D_RI;
						else begin
							state_q <= FILL;
							k_q     <= 8'd0;
						end
					end
				end
				FILL: begin
					k_q <= k_q + 8'd1;
					if (k_q == 8'hFF) begin
						state_q <= K_RD;
						jk_q    <= 8'd0;
						kidx_q  <= '0;
					end
				end
				K_RD: state_q <= K_SK;
				K_SK: begin
					si_q    <= rdata_q;
					jk_q    <= sum;
					state_q <= K_SJ;
				end
				K_SJ: state_q <= K_WJ;
				K_WJ: begin
					k_q    <= k_q + 8'd1;
					kidx_q <= kidx_wrap ? '0 : kidx_q + rc4_pkg::KIDX_W'(1);
					if (k_q == 8'hFF) begin
						state_q <= IDLE;
						i_q     <= 8'd0;
						j_q     <= 8'd0;
					end else
						state_q <= K_RD;
				end
				D_RI: begin
					i_q     <= sum;
					state_q <= D_SI;
				end
				D_SI: begin
					si_q    <= rdata_q;
					j_q     <= sum;
					state_q <= D_SJ;
				end
				D_SJ: begin
					sj_q    <= rdata_q;
					state_q <= D_WJ;
				end
				D_WJ: begin
					// S[j] is written this cycle, so a hit there takes the new value
					fwd_q   <= (sum == j_q);
					state_q <= D_OUT;
				end
				D_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_q.data_out <= din_q ^ ks;
						out_q.last_out <= last_q;
						state_q        <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

// ===== design/rc4_keystream_cipher.sv =====
`default_nettype none
// RC4 stream cipher with a 256 x 8 permutation held in a single-port-write,
// single-read memory and one shared 8-bit adder stepped by a sequencer. An
// init beat (op 0) runs the key schedule over key_length bytes of the key
// registers: an identity fill of all 256 entries, then a swap per entry in
// steps K_RD, K_SK, K_SJ, K_WJ; it gives no result. A data beat (op 1) goes
// through D_RI, D_SI, D_SJ, D_WJ and D_OUT to a registered result, and the
// next beat can be taken once the result is loaded: three dependent reads
// of the one memory read port and two swap writes set this sequence. A
// result still held by out_stall delays the next one. in_stall is high while
// a beat is being worked on. Key registers must be written only while the
// block is idle, which the block does not enforce; cfg_ready is always high.
module rc4_keystream_cipher (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [rc4_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [rc4_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire rc4_pkg::in_t                   in_data,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output rc4_pkg::out_t                       out_data
);

	logic [63:0]                   key_low_q;
	logic [63:0]                   key_high_q;
	logic [rc4_pkg::RAW_LEN_W-1:0] key_length_q;
	logic [127:0]                  key_all;
	rc4_pkg::key_cfg_t             key_cfg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q    <= 64'd0;
			key_high_q   <= 64'd0;
			key_length_q <= rc4_pkg::RAW_LEN_W'(16);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rc4_pkg::REG_KEY_LOW:    key_low_q    <= cfg_data;
				rc4_pkg::REG_KEY_HIGH:   key_high_q   <= cfg_data;
				rc4_pkg::REG_KEY_LENGTH: key_length_q <= cfg_data[rc4_pkg::RAW_LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign key_all   = {key_high_q, key_low_q};

	always_comb begin
		key_cfg.bytes = key_all[rc4_pkg::KEY_W-1:0];
		// zero length acts as one, long lengths saturate
		priority if (key_length_q == '0)
			key_cfg.len = rc4_pkg::LEN_W'(1);
		else if (key_length_q > rc4_pkg::RAW_LEN_W'(rc4_pkg::MAX_KEY_BYTES))
			key_cfg.len = rc4_pkg::LEN_W'(rc4_pkg::MAX_KEY_BYTES);
		else
			key_cfg.len = rc4_pkg::LEN_W'(key_length_q);
	end

	rc4_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_cfg   (key_cfg),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

// ===== design/rc4_checker.sv =====
`default_nettype none
module rc4_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          in_valid,
	input wire logic          in_stall,
	input wire rc4_pkg::in_t  in_data,
	input wire logic          out_valid,
	input wire logic          out_stall,
	input wire rc4_pkg::out_t out_data
);

	// a held result keeps its value
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed or dropped");

	// an accepted beat keeps the block busy, so no beat is taken right after it
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall ##1 in_stall)
		else $error("input taken again too early");

	// a result only appears at the end of a busy period
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without work in progress");

	// no result rises right after an init beat is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (in_data.op == rc4_pkg::OP_INIT) |=> !$rose(out_valid))
		else $error("result after key schedule start");

endmodule

bind rc4_keystream_cipher rc4_checker u_rc4_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
`default_nettype wire
